FILE: sv/tprj_pkg.sv
// Shared widths, codes and control structs of the timestamp pair ratio join.
package tprj_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int SYMBOL_BYTES  = 8;

  localparam int PORT_W    = 2;
  localparam int STAMP_W   = 64;
  localparam int LEVEL_W   = 32;
  localparam int TICKER_W  = 64;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_W = LEVEL_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [TICKER_W-1:0] SYM_MASK =
    {TICKER_W{1'b1}} >> (TICKER_W - 8 * SYMBOL_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_RANGE    = 2'd1,
    CFG_MOVEMENT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_TR   = 2'd1,
    SIDE_DM   = 2'd2
  } side_t;

  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_STORE = 2'd1,
    ACT_DROP  = 2'd2,
    ACT_MATCH = 2'd3
  } action_t;

  typedef struct packed {
    logic load_pass;
    logic store;
    logic start_div;
    logic load_ratio;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    div_busy;
  } stat_t;

endpackage

FILE: sv/tprj_in_if.sv
// Input channel: valid/ready handshake with the message fields.
interface tprj_in_if;
  logic                                valid;
  logic                                ready;
  logic [tprj_pkg::PORT_W-1:0]         in_port;
  logic                                is_indicator;
  logic [tprj_pkg::STAMP_W-1:0]        stamp;
  logic signed [tprj_pkg::LEVEL_W-1:0] level;
  logic [tprj_pkg::TICKER_W-1:0]       ticker;

  modport source (output valid, in_port, is_indicator, stamp, level, ticker, input ready);
  modport sink   (input valid, in_port, is_indicator, stamp, level, ticker, output ready);
endinterface

FILE: sv/tprj_out_if.sv
// Output channel: valid/ready handshake with the result fields.
interface tprj_out_if;
  logic                                valid;
  logic                                ready;
  logic [tprj_pkg::PORT_W-1:0]         out_port;
  logic                                kind;
  logic [tprj_pkg::STAMP_W-1:0]        out_stamp;
  logic signed [tprj_pkg::LEVEL_W-1:0] out_level;
  logic [tprj_pkg::TICKER_W-1:0]       out_ticker;

  modport source (output valid, out_port, kind, out_stamp, out_level, out_ticker, input ready);
  modport sink   (input valid, out_port, kind, out_stamp, out_level, out_ticker, output ready);
endinterface

FILE: sv/tprj_div.sv
// Radix-2 restoring divider on magnitudes with signed saturation of the quotient.
module tprj_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [tprj_pkg::NUM_W-1:0]          num_mag,
  input  logic [tprj_pkg::LEVEL_W-1:0]        den_mag,
  input  logic                                neg,
  input  logic                                den_zero,
  output logic                                busy,
  output logic signed [tprj_pkg::LEVEL_W-1:0] result
);
  import tprj_pkg::*;

  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'({1'b0, {(LEVEL_W-1){1'b1}}});
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'({1'b1, {(LEVEL_W-1){1'b0}}});

  logic [CNT_W-1:0]   count;
  logic [NUM_W-1:0]   quo;
  logic [LEVEL_W-1:0] rem;
  logic [LEVEL_W-1:0] den;
  logic               neg_r;
  logic               zero_r;
  logic [LEVEL_W:0]   rem_shift;
  logic               ge;
  logic [LEVEL_W-1:0] rem_next;
  logic [LEVEL_W-1:0] quo_low;

  assign rem_shift = {rem, quo[NUM_W-1]};
  assign ge        = rem_shift >= {1'b0, den};
  assign rem_next  = ge ? LEVEL_W'(rem_shift - {1'b0, den}) : rem_shift[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo    <= num_mag;
      rem    <= '0;
      den    <= den_mag;
      neg_r  <= neg;
      zero_r <= den_zero;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign quo_low = quo[LEVEL_W-1:0];

  always_comb begin
    if (zero_r) begin
      result = '0;
    end else if (neg_r) begin
      if (quo > NEG_LIM) begin
        result = {1'b1, {(LEVEL_W-1){1'b0}}};
      end else begin
        result = -signed'(quo_low);
      end
    end else begin
      if (quo > POS_LIM) begin
        result = {1'b0, {(LEVEL_W-1){1'b1}}};
      end else begin
        result = signed'(quo_low);
      end
    end
  end
endmodule

FILE: sv/tprj_ctrl.sv
// Controller: sequences accept, divide and result load, and owns the output valid flag.
module tprj_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tprj_pkg::stat_t stat,
  output tprj_pkg::cmd_t  cmd
);
  import tprj_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          unique case (stat.action)
            ACT_PASS:  cmd.load_pass = 1'b1;
            ACT_STORE: cmd.store = 1'b1;
            ACT_DROP:  ;
            ACT_MATCH: begin
              cmd.start_div = 1'b1;
              state_next    = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (!stat.div_busy && slot_free) begin
          cmd.load_ratio = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_pass || cmd.load_ratio) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

FILE: sv/tprj_dpath.sv
// Datapath: configuration, pending message store, item decode, divider and output register.
module tprj_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tprj_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tprj_pkg::CFG_W-1:0]           cfg_data,
  input  logic [tprj_pkg::PORT_W-1:0]          in_port,
  input  logic                                 is_indicator,
  input  logic [tprj_pkg::STAMP_W-1:0]         stamp,
  input  logic signed [tprj_pkg::LEVEL_W-1:0]  level,
  input  logic [tprj_pkg::TICKER_W-1:0]        ticker,
  output logic [tprj_pkg::PORT_W-1:0]          out_port,
  output logic                                 kind,
  output logic [tprj_pkg::STAMP_W-1:0]         out_stamp,
  output logic signed [tprj_pkg::LEVEL_W-1:0]  out_level,
  output logic [tprj_pkg::TICKER_W-1:0]        out_ticker,
  input  tprj_pkg::cmd_t                       cmd,
  output tprj_pkg::stat_t                      stat
);
  import tprj_pkg::*;

  logic                      enable;
  logic signed [CFG_W-1:0]   range_port;
  logic signed [CFG_W-1:0]   movement_port;

  side_t                     pending_side;
  logic [STAMP_W-1:0]        pending_stamp;
  logic signed [LEVEL_W-1:0] pending_level;
  logic [TICKER_W-1:0]       pending_ticker;

  logic [STAMP_W-1:0]        res_stamp;
  logic [TICKER_W-1:0]       res_ticker;

  side_t                     side;
  logic [PORT_W-1:0]         pass_port;
  logic signed [LEVEL_W-1:0] dm_level;
  logic signed [LEVEL_W-1:0] tr_level;
  logic signed [NUM_W-1:0]   num_s;
  logic [NUM_W-1:0]          num_mag;
  logic [LEVEL_W-1:0]        den_mag;
  logic                      div_busy;
  logic signed [LEVEL_W-1:0] quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      range_port    <= '1;
      movement_port <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ENABLE:   enable <= cfg_data[0];
        CFG_RANGE:    range_port <= cfg_data;
        CFG_MOVEMENT: movement_port <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    side = SIDE_NONE;
    if (!range_port[CFG_W-1] && !movement_port[CFG_W-1]) begin
      if (range_port[PORT_W-1:0] == in_port) begin
        side = SIDE_TR;
      end else if (movement_port[PORT_W-1:0] == in_port) begin
        side = SIDE_DM;
      end
    end
  end

  always_comb begin
    pass_port     = in_port;
    stat.action   = ACT_PASS;
    stat.div_busy = div_busy;
    if (enable && !is_indicator) begin
      pass_port = '0;
    end else if (enable && side != SIDE_NONE) begin
      if (pending_side == SIDE_NONE || pending_side == side || stamp > pending_stamp) begin
        stat.action = ACT_STORE;
      end else if (pending_stamp > stamp) begin
        stat.action = ACT_DROP;
      end else begin
        stat.action = ACT_MATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_side <= SIDE_NONE;
    end else if (cmd.store) begin
      pending_side <= side;
    end else if (cmd.start_div) begin
      pending_side <= SIDE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      pending_stamp  <= stamp;
      pending_level  <= level;
      pending_ticker <= ticker;
    end
  end

  assign dm_level = (side == SIDE_TR) ? pending_level : level;
  assign tr_level = (side == SIDE_TR) ? level : pending_level;
  assign num_s    = NUM_W'(dm_level) <<< FRACTION_BITS;
  assign num_mag  = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
  assign den_mag  = tr_level[LEVEL_W-1] ? LEVEL_W'(-tr_level) : LEVEL_W'(tr_level);

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      res_stamp  <= (side == SIDE_TR) ? stamp : pending_stamp;
      res_ticker <= ((side == SIDE_TR) ? ticker : pending_ticker) & SYM_MASK;
    end
  end

  tprj_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .num_mag  (num_mag),
    .den_mag  (den_mag),
    .neg      (dm_level[LEVEL_W-1] ^ tr_level[LEVEL_W-1]),
    .den_zero (tr_level == '0),
    .busy     (div_busy),
    .result   (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_pass) begin
      out_port   <= pass_port;
      kind       <= 1'b0;
      out_stamp  <= stamp;
      out_level  <= level;
      out_ticker <= ticker;
    end else if (cmd.load_ratio) begin
      out_port   <= '0;
      kind       <= 1'b1;
      out_stamp  <= res_stamp;
      out_level  <= quotient;
      out_ticker <= res_ticker;
    end
  end
endmodule

FILE: sv/timestamp_pair_ratio_join.sv
// Top level of the timestamp pair ratio join: controller, datapath and channel wiring.
//
//   Channel   Direction  Handshake            Payload
//   in_ch     sink       valid/ready          in_port, is_indicator, stamp, level, ticker
//   out_ch    source     valid/ready          out_port, kind, out_stamp, out_level, out_ticker
//   cfg       sink       cfg_we, no stall     cfg_index, cfg_data
//
// A passthrough, stored or dropped transaction is handled in S_IDLE, and the next one can be
// accepted in the following cycle, also while the output register holds a result if out_ch.ready is high.
// A matching pair starts the radix-2 divider, which produces one quotient bit per cycle;
// no transaction is accepted until the quotient is loaded into the output register.
// The output register holds its result until out_ch.ready is high.
// Reset is synchronous; it clears the pending store and restores the configuration.
module timestamp_pair_ratio_join (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tprj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tprj_pkg::CFG_W-1:0]     cfg_data,
  tprj_in_if.sink                        in_ch,
  tprj_out_if.source                     out_ch
);
  import tprj_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tprj_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tprj_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_port      (in_ch.in_port),
    .is_indicator (in_ch.is_indicator),
    .stamp        (in_ch.stamp),
    .level        (in_ch.level),
    .ticker       (in_ch.ticker),
    .out_port     (out_ch.out_port),
    .kind         (out_ch.kind),
    .out_stamp    (out_ch.out_stamp),
    .out_level    (out_ch.out_level),
    .out_ticker   (out_ch.out_ticker),
    .cmd          (cmd),
    .stat         (stat)
  );

  a_no_accept_while_dividing: assert property (
    @(posedge clk) disable iff (rst) stat.div_busy |-> !in_ch.ready
  ) else $error("input accepted while the divider is busy");

  a_no_overwrite_of_waiting_result: assert property (
    @(posedge clk) disable iff (rst) (out_ch.valid && !out_ch.ready) |->
      !(cmd.load_pass || cmd.load_ratio)
  ) else $error("output register loaded while its result waits");

  a_divider_starts: assert property (
    @(posedge clk) disable iff (rst) cmd.start_div |=> stat.div_busy
  ) else $error("divider did not start on a matching pair");
endmodule
